// File: rtl/core/ratbl_pkg.sv
// Shared types, field widths and codes of the resource allocation table.
// No dependencies; ratbl_totals, ratbl_seq and the top level import this package.
`timescale 1ns / 1ps

package ratbl_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_NUM_PROCESSES = 32;
  localparam int DEF_NUM_CLASSES   = 5;
  localparam int DEF_MAX_UNITS     = 15;

  // Field widths of the stream payloads
  localparam int FUNC_W    = 2;
  localparam int PROC_W    = 5;
  localparam int CLASS_W   = 3;
  localparam int QTY_W     = 4;
  localparam int STATUS_W  = 3;
  localparam int COUNT_W   = 4;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;

  // Configuration register file
  localparam int NUM_REGS  = 5;
  localparam int REG_IDX_W = 3;
  localparam int TOTAL_W   = 4;
  localparam logic [TOTAL_W-1:0] TOTAL_RESET = 4'd10;

  // Operation codes
  localparam logic [FUNC_W-1:0] F_REQUEST   = 2'd0;
  localparam logic [FUNC_W-1:0] F_RELEASE   = 2'd1;
  localparam logic [FUNC_W-1:0] F_TERMINATE = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_GRANTED      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DENIED       = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RELEASED     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RECLAIMED    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OVER_RELEASE = 3'd4;

  typedef struct packed {
    logic [QTY_W-1:0]   quantity;
    logic [CLASS_W-1:0] resource;
    logic [PROC_W-1:0]  process;
    logic [FUNC_W-1:0]  func;
  } item_t;

  typedef struct packed {
    logic [COUNT_W-1:0]  held_after;
    logic [COUNT_W-1:0]  free_after;
    logic [STATUS_W-1:0] status;
  } result_t;

  typedef logic [NUM_REGS-1:0][TOTAL_W-1:0] total_vec_t;

endpackage

// File: rtl/core/ratbl_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module ratbl_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 160,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/ratbl_totals.sv
// Configuration register file holding the total instances of each class.
// Depends on ratbl_pkg.
`timescale 1ns / 1ps

module ratbl_totals import ratbl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [TOTAL_W-1:0]   cfg_data,
  output total_vec_t           totals
);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        totals[i] <= TOTAL_RESET;
      end
    end else if (cfg_wr_en && (32'(cfg_index) < NUM_REGS)) begin
      totals[cfg_index] <= cfg_data;
    end
  end

endmodule

// File: rtl/core/ratbl_seq.sv
// Operation sequencer: clears the held-units RAM after reset, then runs
// read-modify-write passes for request, release and terminate.
// Depends on ratbl_pkg and ratbl_ram.
`timescale 1ns / 1ps

module ratbl_seq import ratbl_pkg::*; #(
  parameter int NUM_PROCESSES = DEF_NUM_PROCESSES,
  parameter int NUM_CLASSES   = DEF_NUM_CLASSES,
  parameter int MAX_UNITS     = DEF_MAX_UNITS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  item_t      item,
  input  total_vec_t totals,
  output logic       res_valid,
  input  logic       res_ready,
  output result_t    res
);

  localparam int DEPTH = NUM_PROCESSES * NUM_CLASSES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int UW    = $clog2(MAX_UNITS + 1);
  localparam int VW    = ((UW > COUNT_W) ? UW : COUNT_W) + 1;
  localparam int CIW   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RMW   = 3'd2;
  localparam logic [2:0] S_TERM  = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  logic [2:0]          state;
  logic [AW-1:0]       clr_addr;
  logic [FUNC_W-1:0]   func_r;
  logic [PROC_W-1:0]   proc_r;
  logic [CLASS_W-1:0]  res_r;
  logic [QTY_W-1:0]    qty_r;
  logic                res_ok_r;
  logic [UW-1:0]       held_r;
  logic [STATUS_W-1:0] status_r;
  logic [CLASS_W-1:0]  tj;
  logic [CLASS_W-1:0]  pj;
  logic                pend;
  logic [UW-1:0]       in_use [NUM_CLASSES];

  logic                ram_wr_en;
  logic [AW-1:0]       ram_wr_addr;
  logic [UW-1:0]       ram_wr_data;
  logic                ram_rd_en;
  logic [AW-1:0]       ram_rd_addr;
  logic [UW-1:0]       ram_rd_data;

  logic                proc_ok_in;
  logic                res_ok_in;
  logic [UW-1:0]       u_res;
  logic [TOTAL_W-1:0]  tot_res;
  logic [COUNT_W-1:0]  free_res;
  logic [VW-1:0]       h_plus;
  logic [VW-1:0]       u_plus;
  logic                grant;
  logic                over;
  logic                tj_live;

  function automatic logic [AW-1:0] addr_of(input logic [PROC_W-1:0] p,
                                            input logic [CLASS_W-1:0] c);
    return AW'(int'(p) * NUM_CLASSES + int'(c));
  endfunction

  assign proc_ok_in = 32'(item.process) < NUM_PROCESSES;
  assign res_ok_in  = 32'(item.resource) < NUM_CLASSES;
  assign tj_live    = 32'(tj) < NUM_CLASSES;

  always_comb begin
    u_res    = in_use[res_r[CIW-1:0]];
    tot_res  = res_ok_r ? totals[res_r] : '0;
    free_res = '0;
    if (res_ok_r && (VW'(tot_res) > VW'(u_res))) begin
      free_res = COUNT_W'(VW'(tot_res) - VW'(u_res));
    end
    h_plus = VW'(ram_rd_data) + VW'(qty_r);
    u_plus = VW'(u_res) + VW'(qty_r);
    grant  = (VW'(free_res) >= VW'(qty_r)) && (h_plus <= VW'(MAX_UNITS)) &&
             (u_plus <= VW'(MAX_UNITS));
    over   = VW'(qty_r) > VW'(ram_rd_data);
  end

  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = addr_of(proc_r, res_r);
    ram_wr_data = '0;
    ram_rd_en   = 1'b0;
    ram_rd_addr = addr_of(item.process, item.resource);
    case (state)
      S_CLEAR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = clr_addr;
      end
      S_IDLE: begin
        ram_rd_en = in_valid && proc_ok_in && res_ok_in && (item.func != F_TERMINATE);
      end
      S_RMW: begin
        if (func_r == F_REQUEST && grant) begin
          ram_wr_en   = 1'b1;
          ram_wr_data = UW'(h_plus);
        end else if (func_r == F_RELEASE && !over) begin
          ram_wr_en   = 1'b1;
          ram_wr_data = UW'(VW'(ram_rd_data) - VW'(qty_r));
        end
      end
      S_TERM: begin
        ram_rd_en   = tj_live;
        ram_rd_addr = addr_of(proc_r, tj);
        // zero the entry whose old count just came back
        ram_wr_en   = pend;
        ram_wr_addr = addr_of(proc_r, pj);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      tj       <= '0;
      pend     <= 1'b0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        in_use[i] <= '0;
      end
    end else begin
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            func_r   <= item.func;
            proc_r   <= item.process;
            res_r    <= item.resource;
            qty_r    <= item.quantity;
            res_ok_r <= res_ok_in;
            held_r   <= '0;
            status_r <= ST_DENIED;
            tj       <= '0;
            pend     <= 1'b0;
            if (proc_ok_in && item.func == F_TERMINATE) begin
              state <= S_TERM;
            end else if (proc_ok_in && res_ok_in) begin
              state <= S_RMW;
            end else begin
              state <= S_RESP;
            end
          end
        end
        S_RMW: begin
          held_r <= ram_rd_data;
          if (func_r == F_REQUEST) begin
            if (grant) begin
              held_r               <= UW'(h_plus);
              in_use[res_r[CIW-1:0]] <= UW'(u_plus);
              status_r             <= ST_GRANTED;
            end
          end else if (func_r == F_RELEASE) begin
            if (over) begin
              status_r <= ST_OVER_RELEASE;
            end else begin
              held_r   <= UW'(VW'(ram_rd_data) - VW'(qty_r));
              status_r <= ST_RELEASED;
              if (VW'(u_res) >= VW'(qty_r)) begin
                in_use[res_r[CIW-1:0]] <= UW'(VW'(u_res) - VW'(qty_r));
              end else begin
                in_use[res_r[CIW-1:0]] <= '0;
              end
            end
          end
          state <= S_RESP;
        end
        S_TERM: begin
          if (tj_live) begin
            tj <= tj + 1'b1;
          end
          pend <= tj_live;
          pj   <= tj;
          if (pend) begin
            if (in_use[pj[CIW-1:0]] >= ram_rd_data) begin
              in_use[pj[CIW-1:0]] <= in_use[pj[CIW-1:0]] - ram_rd_data;
            end else begin
              in_use[pj[CIW-1:0]] <= '0;
            end
            if (!tj_live) begin
              status_r <= ST_RECLAIMED;
              state    <= S_RESP;
            end
          end
        end
        S_RESP: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready       = state == S_IDLE;
  assign res_valid      = state == S_RESP;
  assign res.status     = status_r;
  assign res.free_after = free_res;
  assign res.held_after = COUNT_W'(held_r);

  ratbl_ram #(
    .WIDTH(UW),
    .DEPTH(DEPTH)
  ) u_held_ram (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

endmodule

// File: rtl/core/resource_allocation_table.sv
// Resource allocation table: top level with stream ports, configuration
// write port and output register. Depends on ratbl_pkg, ratbl_totals, ratbl_seq.
//
// Usage:
//   The slave stream (s_tvalid/s_tready/s_tdata) carries one operation per
//   transaction: request, release or terminate for one process and class.
//   The master stream (m_tvalid/m_tready/m_tdata) returns one result per
//   operation, in order: status, free units of the class and units the
//   process still holds of it.
//   The configuration port writes the total of each class; write it only
//   while no operation is in flight.
//   One operation is worked at a time. An in-range request, release or
//   unknown operation goes from acceptance to the output register through
//   accept and RAM read, modify/write back and result; a terminate walks the
//   process row of the held-units RAM, one class per cycle. A new operation
//   is taken once the result has moved to the output register.
//   After reset the held-units RAM (NUM_PROCESSES * NUM_CLASSES entries, 160
//   by default) is cleared one entry a cycle with s_tready low; totals
//   return to 10 and class in-use counts to 0.
//   A stalled receiver holds the result in the output register; the next
//   operation is still accepted and its result waits until the register frees.
`timescale 1ns / 1ps

module resource_allocation_table import ratbl_pkg::*; #(
  parameter int NUM_PROCESSES = DEF_NUM_PROCESSES,
  parameter int NUM_CLASSES   = DEF_NUM_CLASSES,
  parameter int MAX_UNITS     = DEF_MAX_UNITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // func[1:0], process[6:2], resource[9:7], quantity[13:10], zero pad above
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // status[2:0], free_after[6:3], held_after[10:7], zero pad above
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_wr_en,
  input  logic [REG_IDX_W-1:0]  cfg_index,
  input  logic [TOTAL_W-1:0]    cfg_data
);

  localparam int RES_W = $bits(result_t);

  item_t      item;
  total_vec_t totals;
  logic       res_valid;
  logic       res_ready;
  result_t    res;

  assign item      = item_t'(s_tdata[$bits(item_t)-1:0]);
  assign res_ready = !m_tvalid || m_tready;

  ratbl_totals u_totals (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .totals   (totals)
  );

  ratbl_seq #(
    .NUM_PROCESSES(NUM_PROCESSES),
    .NUM_CLASSES  (NUM_CLASSES),
    .MAX_UNITS    (MAX_UNITS)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .item     (item),
    .totals   (totals),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  // Output register: load on a finished result, drop once the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= {{(OUT_DATA_W - RES_W){1'b0}}, res};
    end
  end

endmodule
